### rtl/fpda_pkg.sv
// ----------------------------------------------------------------------------
// fpda_pkg
// Shared constants, register codes and types of the decimal ASCII formatter.
// ----------------------------------------------------------------------------
package fpda_pkg;

	localparam int DEF_INT_BITS   = 24;
	localparam int DEF_FRAC_BITS  = 16;
	localparam int DEF_MAX_DIGITS = 8;
	localparam int DEF_MAX_FIELD  = 32;

	localparam int DIG_CNT_W  = 4;
	localparam int CHAR_W     = 8;
	localparam int FLEN_W     = 6;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	localparam logic [CHAR_W-1:0] ASCII_ZERO = 8'd48;
	localparam logic [CHAR_W-1:0] MINUS_CHAR = 8'h2D;
	localparam int                RADIX      = 10;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_WHOLE_DIGITS    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRACTION_DIGITS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DELIMITER_CHAR  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FIELD_LENGTH    = 2'd3;

	localparam logic [DIG_CNT_W-1:0] RST_WHOLE_DIGITS    = 4'd4;
	localparam logic [DIG_CNT_W-1:0] RST_FRACTION_DIGITS = 4'd3;
	localparam logic [CHAR_W-1:0]    RST_DELIMITER_CHAR  = 8'd44;
	localparam logic [FLEN_W-1:0]    RST_FIELD_LENGTH    = 6'd10;

	// format of the field being emitted, fixed at the accepted transaction
	typedef struct packed {
		logic [DIG_CNT_W-1:0] nw;
		logic [DIG_CNT_W-1:0] nf;
		logic [CHAR_W-1:0]    delim;
		logic [FLEN_W-1:0]    len;
		logic                 neg;
	} fpda_fmt_t;

endpackage

### rtl/fixed_point_to_decimal_ascii_core.sv
// ----------------------------------------------------------------------------
// fixed_point_to_decimal_ascii_core
// Formats a signed fixed-point value as a fixed-length decimal ASCII field.
// ----------------------------------------------------------------------------
// One value is taken at a time. After acceptance the conversion unit iterates
// over the INT_BITS integer bits (one double-dabble bit per cycle) and the
// MAX_DIGITS fractional digits (one per cycle) side by side, then the field
// goes out at one character per cycle while the output is not stalled.
// in_stall stays high until the last character of the field has been taken.
// Registers are to be written only while idle.
// ----------------------------------------------------------------------------
module fixed_point_to_decimal_ascii_core
	import fpda_pkg::*;
#(
	parameter int INT_BITS   = DEF_INT_BITS,
	parameter int FRAC_BITS  = DEF_FRAC_BITS,
	parameter int MAX_DIGITS = DEF_MAX_DIGITS,
	parameter int MAX_FIELD  = DEF_MAX_FIELD
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [CFG_IDX_W-1:0]          cfg_index,
	input  logic [CFG_DATA_W-1:0]         cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [INT_BITS+FRAC_BITS-1:0] value,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [CHAR_W-1:0]             character,
	output logic                          last_char
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_CONV = 2'd1;
	localparam logic [1:0] S_EMIT = 2'd2;

	logic [1:0]           state_q;
	logic [DIG_CNT_W-1:0] whole_digits_q;
	logic [DIG_CNT_W-1:0] fraction_digits_q;
	logic [CHAR_W-1:0]    delimiter_char_q;
	logic [FLEN_W-1:0]    field_length_q;
	fpda_fmt_t            fmt_q;
	fpda_fmt_t            fmt_next;

	logic                    in_accept;
	logic                    conv_done;
	logic                    emit_done;
	logic [4*MAX_DIGITS-1:0] whole_bcd;
	logic [4*MAX_DIGITS-1:0] frac_bcd;

	assign in_stall  = (state_q != S_IDLE);
	assign in_accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			whole_digits_q    <= RST_WHOLE_DIGITS;
			fraction_digits_q <= RST_FRACTION_DIGITS;
			delimiter_char_q  <= RST_DELIMITER_CHAR;
			field_length_q    <= RST_FIELD_LENGTH;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WHOLE_DIGITS:    whole_digits_q    <= cfg_data[DIG_CNT_W-1:0];
				REG_FRACTION_DIGITS: fraction_digits_q <= cfg_data[DIG_CNT_W-1:0];
				REG_DELIMITER_CHAR:  delimiter_char_q  <= cfg_data[CHAR_W-1:0];
				REG_FIELD_LENGTH:    field_length_q    <= cfg_data[FLEN_W-1:0];
				default: ;
			endcase
		end
	end

	// clamp digit counts and field length
	always_comb begin
		fmt_next.nw = (whole_digits_q > DIG_CNT_W'(MAX_DIGITS)) ? DIG_CNT_W'(MAX_DIGITS)
		                                                        : whole_digits_q;
		fmt_next.nf = (fraction_digits_q > DIG_CNT_W'(MAX_DIGITS)) ? DIG_CNT_W'(MAX_DIGITS)
		                                                           : fraction_digits_q;
		fmt_next.delim = delimiter_char_q;
		if (field_length_q == '0)
			fmt_next.len = FLEN_W'(1);
		else if ({1'b0, field_length_q} > (FLEN_W+1)'(MAX_FIELD))
			fmt_next.len = FLEN_W'(MAX_FIELD);
		else
			fmt_next.len = field_length_q;
		fmt_next.neg = value[INT_BITS+FRAC_BITS-1];
	end

	always_ff @(posedge clk) begin
		if (in_accept)
			fmt_q <= fmt_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_accept) state_q <= S_CONV;
				S_CONV: if (conv_done) state_q <= S_EMIT;
				S_EMIT: if (emit_done) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	fpda_convert #(
		.INT_BITS   (INT_BITS),
		.FRAC_BITS  (FRAC_BITS),
		.MAX_DIGITS (MAX_DIGITS)
	) u_convert (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (in_accept),
		.value     (value),
		.done      (conv_done),
		.whole_bcd (whole_bcd),
		.frac_bcd  (frac_bcd)
	);

	fpda_emit #(
		.MAX_DIGITS (MAX_DIGITS)
	) u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (conv_done && (state_q == S_CONV)),
		.fmt       (fmt_q),
		.whole_bcd (whole_bcd),
		.frac_bcd  (frac_bcd),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.character (character),
		.last_char (last_char),
		.done      (emit_done)
	);

endmodule

### rtl/fpda_convert.sv
// ----------------------------------------------------------------------------
// fpda_convert
// Iterative binary to decimal unit: one double-dabble shift of the integer
// part and one multiply-by-ten of the fraction per cycle.
// ----------------------------------------------------------------------------
module fpda_convert
	import fpda_pkg::*;
#(
	parameter int INT_BITS   = DEF_INT_BITS,
	parameter int FRAC_BITS  = DEF_FRAC_BITS,
	parameter int MAX_DIGITS = DEF_MAX_DIGITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [INT_BITS+FRAC_BITS-1:0] value,
	output logic                          done,
	output logic [4*MAX_DIGITS-1:0]       whole_bcd,
	output logic [4*MAX_DIGITS-1:0]       frac_bcd
);

	localparam int VW    = INT_BITS + FRAC_BITS;
	localparam int STEPS = (INT_BITS > MAX_DIGITS) ? INT_BITS : MAX_DIGITS;
	localparam int CNT_W = $clog2(STEPS);
	localparam int PW    = FRAC_BITS + 4;

	logic                    busy_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [INT_BITS-1:0]     ipart_q;
	logic [FRAC_BITS-1:0]    frac_q;
	logic [4*MAX_DIGITS-1:0] bcd_q;
	logic [4*MAX_DIGITS-1:0] fbcd_q;

	logic [VW-1:0]           mag;
	logic [4*MAX_DIGITS-1:0] adj;
	logic [4*MAX_DIGITS-1:0] dabble_next;
	logic [PW-1:0]           prod;
	logic [4*MAX_DIGITS+3:0] fshift;
	logic                    int_step;
	logic                    frac_step;

	// most negative value gives 2^(VW-1), which still fits unsigned
	assign mag = value[VW-1] ? (~value + VW'(1)) : value;

	always_comb begin
		for (int k = 0; k < MAX_DIGITS; k++) begin
			adj[4*k +: 4] = (bcd_q[4*k +: 4] >= 4'd5) ? (bcd_q[4*k +: 4] + 4'd3)
			                                          : bcd_q[4*k +: 4];
		end
	end

	// carry out of the top digit is dropped: integer part modulo 10^MAX_DIGITS
	assign dabble_next = {adj[4*MAX_DIGITS-2:0], ipart_q[INT_BITS-1]};
	assign prod        = {4'b0, frac_q} * PW'(RADIX);
	assign fshift      = {prod[FRAC_BITS +: 4], fbcd_q};
	assign int_step    = {1'b0, cnt_q} < (CNT_W+1)'(INT_BITS);
	assign frac_step   = {1'b0, cnt_q} < (CNT_W+1)'(MAX_DIGITS);
	assign done        = busy_q && (cnt_q == CNT_W'(STEPS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CNT_W'(1);
			if (done)
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ipart_q <= mag[VW-1:FRAC_BITS];
			frac_q  <= mag[FRAC_BITS-1:0];
			bcd_q   <= '0;
		end else if (busy_q) begin
			if (int_step) begin
				bcd_q   <= dabble_next;
				ipart_q <= {ipart_q[INT_BITS-2:0], 1'b0};
			end
			// first fractional digit ends up in entry 0
			if (frac_step) begin
				frac_q <= prod[FRAC_BITS-1:0];
				fbcd_q <= fshift[4*MAX_DIGITS+3:4];
			end
		end
	end

	assign whole_bcd = bcd_q;
	assign frac_bcd  = fbcd_q;

endmodule

### rtl/fpda_emit.sv
// ----------------------------------------------------------------------------
// fpda_emit
// Character sequencer: walks the field one position per transaction and
// holds the current character in the output register.
// ----------------------------------------------------------------------------
module fpda_emit
	import fpda_pkg::*;
#(
	parameter int MAX_DIGITS = DEF_MAX_DIGITS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  fpda_fmt_t               fmt,
	input  logic [4*MAX_DIGITS-1:0] whole_bcd,
	input  logic [4*MAX_DIGITS-1:0] frac_bcd,
	input  logic                    out_stall,
	output logic                    out_valid,
	output logic [CHAR_W-1:0]       character,
	output logic                    last_char,
	output logic                    done
);

	localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

	logic              active_q;
	logic [FLEN_W-1:0] pos_q;
	logic              out_valid_q;
	logic [CHAR_W-1:0] char_q;
	logic              last_q;

	logic              load;
	logic              is_last;
	logic [FLEN_W-1:0] seq;
	logic [FLEN_W-1:0] nw_ext;
	logic [FLEN_W-1:0] nf_ext;
	logic [FLEN_W-1:0] widx;
	logic [FLEN_W-1:0] fidx;
	logic [3:0]        wdig;
	logic [3:0]        fdig;
	logic [CHAR_W-1:0] char_next;

	assign load    = active_q && (!out_valid_q || !out_stall);
	assign is_last = ({1'b0, pos_q} + 7'd1) == {1'b0, fmt.len};

	// position within the digit sequence, the sign taking slot zero
	assign seq    = pos_q - {{(FLEN_W-1){1'b0}}, fmt.neg};
	assign nw_ext = FLEN_W'(fmt.nw);
	assign nf_ext = FLEN_W'(fmt.nf);
	assign widx   = nw_ext - FLEN_W'(1) - seq;
	assign fidx   = seq - nw_ext - FLEN_W'(1);
	assign wdig   = whole_bcd[4*widx[IDX_W-1:0] +: 4];
	assign fdig   = frac_bcd[4*fidx[IDX_W-1:0] +: 4];

	always_comb begin
		if (fmt.neg && (pos_q == '0))
			char_next = MINUS_CHAR;
		else if (seq < nw_ext)
			char_next = ASCII_ZERO + {4'b0, wdig};
		else if (seq == nw_ext)
			char_next = fmt.delim;
		else if (fidx < nf_ext)
			char_next = ASCII_ZERO + {4'b0, fdig};
		else
			char_next = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (start) begin
				active_q <= 1'b1;
				pos_q    <= '0;
			end else if (load) begin
				pos_q <= pos_q + FLEN_W'(1);
				if (is_last)
					active_q <= 1'b0;
			end
			if (load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			char_q <= char_next;
			last_q <= is_last;
		end
	end

	assign out_valid = out_valid_q;
	assign character = char_q;
	assign last_char = last_q;
	assign done      = out_valid_q && !out_stall && last_q;

endmodule

### rtl/fpda_checker.sv
// ----------------------------------------------------------------------------
// fpda_checker
// Port-level checks of the formatter, bound to the top level.
// ----------------------------------------------------------------------------
module fpda_checker
	import fpda_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic              out_valid,
	input logic              out_stall,
	input logic [CHAR_W-1:0] character,
	input logic              last_char
);

	// busy from the transaction onwards
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input ready right after an accepted transaction");

	// nothing pending on the output while the block is ready
	a_idle_no_output: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |-> !out_valid)
		else $error("output valid while idle");

	// the field ends with its flagged character
	a_end_of_field: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && last_char |=> !out_valid)
		else $error("character after end of field");

	// hold a stalled character
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(character) && $stable(last_char))
		else $error("stalled output changed");

endmodule

bind fixed_point_to_decimal_ascii_core fpda_checker u_fpda_checker (.*);
